// ===== design/g2l_pkg.sv =====
// Package for the global-to-local frame transform.
// Holds shared widths, the CORDIC gain and the arctangent table; no dependencies.
package g2l_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CARRY_WIDTH       = 32;
    localparam int GUARD_BITS        = 8;
    localparam int TURN_WIDTH        = 32;
    localparam int GAIN_WIDTH        = 31;
    localparam int GROWTH_BITS       = 4;
    localparam logic [GAIN_WIDTH-1:0] CORDIC_GAIN_Q31 = 31'd1304065748;

    // arctan(2^-i) as a fraction of a 32-bit full turn, rounded
    function automatic logic [TURN_WIDTH-1:0] atan_turn(input int idx);
        logic [TURN_WIDTH-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/g2l_rot_stage.sv =====
// One registered CORDIC micro-rotation stage.
// Uses g2l_pkg for the arctangent table and turn width.
module g2l_rot_stage #(
    parameter int W   = 44,
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [W-1:0]               i_x,
    input  logic signed [W-1:0]               i_y,
    input  logic [g2l_pkg::TURN_WIDTH-1:0]    i_z,
    output logic                              o_valid,
    output logic signed [W-1:0]               o_x,
    output logic signed [W-1:0]               o_y,
    output logic [g2l_pkg::TURN_WIDTH-1:0]    o_z
);

    localparam logic [g2l_pkg::TURN_WIDTH-1:0] ATAN = g2l_pkg::atan_turn(IDX);

    logic signed [W-1:0] w_xs;
    logic signed [W-1:0] w_ys;
    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [g2l_pkg::TURN_WIDTH-1:0] r_z;

    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (!i_z[g2l_pkg::TURN_WIDTH-1]) begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== design/g2l_scale.sv =====
// Gain compensation, rounding and saturation of one CORDIC output, four stages.
// Uses g2l_pkg for the gain constant and guard bits.
module g2l_scale #(
    parameter int W = 44,
    parameter int C = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_value,
    output logic                o_valid,
    output logic [C-1:0]        o_value,
    output logic                o_clip
);

    localparam int LO_W  = W / 2;
    localparam int HI_W  = W - LO_W;
    localparam int GW    = g2l_pkg::GAIN_WIDTH;
    localparam int SUM_W = W + GW;
    localparam int SH    = GW + g2l_pkg::GUARD_BITS;
    localparam int R_W   = SUM_W - SH;
    localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (SH - 1);
    localparam logic [R_W-1:0]   LIM   = R_W'(1) << (C - 1);

    logic [3:0]            r_valid;
    logic [2:0]            r_neg;
    logic [W-1:0]          r_mag;
    logic [HI_W+GW-1:0]    r_phi;
    logic [LO_W+GW-1:0]    r_plo;
    logic [R_W-1:0]        r_rnd;
    logic [C-1:0]          r_out;
    logic                  r_clip;
    logic [SUM_W-1:0]      w_sum;
    logic [R_W-1:0]        w_lim_val;
    logic                  w_clip;

    assign w_sum = {r_phi, {LO_W{1'b0}}} + SUM_W'(r_plo) + ROUND;

    always_comb begin
        w_clip    = 1'b0;
        w_lim_val = r_rnd;
        if (r_neg[2]) begin
            if (r_rnd > LIM) begin
                w_clip    = 1'b1;
                w_lim_val = LIM;
            end
        end else if (r_rnd > LIM - R_W'(1)) begin
            w_clip    = 1'b1;
            w_lim_val = LIM - R_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
            r_neg   <= {r_neg[1:0], i_value[W-1]};
            r_mag   <= i_value[W-1] ? W'(-i_value) : W'(i_value);
            r_phi   <= r_mag[W-1:LO_W] * g2l_pkg::CORDIC_GAIN_Q31;
            r_plo   <= r_mag[LO_W-1:0] * g2l_pkg::CORDIC_GAIN_Q31;
            r_rnd   <= w_sum[SUM_W-1:SH];
            r_clip  <= w_clip;
            r_out   <= r_neg[2] ? C'(-w_lim_val) : C'(w_lim_val);
        end
    end

    assign o_valid = r_valid[3];
    assign o_value = r_out;
    assign o_clip  = r_clip;

endmodule

// ===== design/global_to_local_frame_top.sv =====
// Top level of the global-to-local frame transform.
// Uses g2l_pkg, g2l_rot_stage and g2l_scale.
//
// Takes one pose pair per clock while o_s_axis_tready is high and returns one
// result per input, in order. The offset target minus reference is rotated by
// minus the reference heading through a pipeline of CORDIC_STAGES registered
// micro-rotations, then scaled by the CORDIC gain, rounded and saturated to
// COORD_WIDTH bits. The registered path runs through one input stage, one
// quadrant stage, the CORDIC stages, four scaling stages and the output
// register. Throughput is one transaction per cycle; a one-entry skid buffer
// behind the pipeline absorbs back-pressure, and o_s_axis_tready drops only
// while it is occupied.
module global_to_local_frame_top #(
    parameter int COORD_WIDTH   = g2l_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = g2l_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = g2l_pkg::CORDIC_STAGES_DEF,
    localparam int IN_RAW  = 4 * COORD_WIDTH + 2 * ANGLE_WIDTH + g2l_pkg::CARRY_WIDTH,
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW = 2 * COORD_WIDTH + ANGLE_WIDTH + g2l_pkg::CARRY_WIDTH,
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // ref_x, ref_y, ref_heading, tgt_x, tgt_y, tgt_heading, carried_value
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // local_x, local_y, local_heading, carried_out
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // saturated
    output logic              o_m_axis_tuser
);

    localparam int C      = COORD_WIDTH;
    localparam int A      = ANGLE_WIDTH;
    localparam int N      = CORDIC_STAGES;
    localparam int CW     = g2l_pkg::CARRY_WIDTH;
    localparam int TW     = g2l_pkg::TURN_WIDTH;
    localparam int W      = C + g2l_pkg::GUARD_BITS + g2l_pkg::GROWTH_BITS;
    localparam int SIDE_D = N + 5;
    localparam int PAY_W  = OUT_RAW + 1;

    logic w_en;

    // input field slices
    logic signed [C-1:0] w_ref_x;
    logic signed [C-1:0] w_ref_y;
    logic [A-1:0]        w_ref_h;
    logic signed [C-1:0] w_tgt_x;
    logic signed [C-1:0] w_tgt_y;
    logic [A-1:0]        w_tgt_h;
    logic [CW-1:0]       w_carry;

    assign w_ref_x = i_s_axis_tdata[C-1:0];
    assign w_ref_y = i_s_axis_tdata[2*C-1:C];
    assign w_ref_h = i_s_axis_tdata[2*C+A-1:2*C];
    assign w_tgt_x = i_s_axis_tdata[3*C+A-1:2*C+A];
    assign w_tgt_y = i_s_axis_tdata[4*C+A-1:3*C+A];
    assign w_tgt_h = i_s_axis_tdata[4*C+2*A-1:4*C+A];
    assign w_carry = i_s_axis_tdata[4*C+2*A+CW-1:4*C+2*A];

    // stage 1: differences
    logic                r_s1_valid;
    logic signed [C:0]   r_s1_dx;
    logic signed [C:0]   r_s1_dy;
    logic [TW-1:0]       r_s1_z;
    logic [A-1:0]        r_s1_hd;
    logic [CW-1:0]       r_s1_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_s_axis_tvalid;
            r_s1_dx    <= (C+1)'(w_tgt_x) - (C+1)'(w_ref_x);
            r_s1_dy    <= (C+1)'(w_tgt_y) - (C+1)'(w_ref_y);
            r_s1_z     <= {A'(-w_ref_h), {(TW-A){1'b0}}};
            r_s1_hd    <= A'(w_tgt_h - w_ref_h);
            r_s1_carry <= w_carry;
        end
    end

    // stage 2: guard shift and quadrant fold
    logic signed [W-1:0] w_x0;
    logic signed [W-1:0] w_y0;
    logic                w_fold;
    logic                r_s2_valid;
    logic signed [W-1:0] r_s2_x;
    logic signed [W-1:0] r_s2_y;
    logic [TW-1:0]       r_s2_z;

    assign w_x0   = W'(r_s1_dx) <<< g2l_pkg::GUARD_BITS;
    assign w_y0   = W'(r_s1_dy) <<< g2l_pkg::GUARD_BITS;
    assign w_fold = r_s1_z[TW-1] ^ r_s1_z[TW-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
            r_s2_x     <= w_fold ? -w_x0 : w_x0;
            r_s2_y     <= w_fold ? -w_y0 : w_y0;
            r_s2_z     <= {r_s1_z[TW-1] ^ w_fold, r_s1_z[TW-2:0]};
        end
    end

    // CORDIC pipeline
    logic                w_cv [0:N];
    logic signed [W-1:0] w_cx [0:N];
    logic signed [W-1:0] w_cy [0:N];
    logic [TW-1:0]       w_cz [0:N];

    assign w_cv[0] = r_s2_valid;
    assign w_cx[0] = r_s2_x;
    assign w_cy[0] = r_s2_y;
    assign w_cz[0] = r_s2_z;

    for (genvar g = 0; g < N; g++) begin : g_rot
        g2l_rot_stage #(
            .W   (W),
            .IDX (g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .o_valid (w_cv[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1])
        );
    end

    // gain, rounding, saturation
    logic         w_sx_valid;
    logic         w_sy_valid;
    logic [C-1:0] w_lx;
    logic [C-1:0] w_ly;
    logic         w_clip_x;
    logic         w_clip_y;

    g2l_scale #(.W(W), .C(C)) u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv[N]),
        .i_value (w_cx[N]),
        .o_valid (w_sx_valid),
        .o_value (w_lx),
        .o_clip  (w_clip_x)
    );

    g2l_scale #(.W(W), .C(C)) u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv[N]),
        .i_value (w_cy[N]),
        .o_valid (w_sy_valid),
        .o_value (w_ly),
        .o_clip  (w_clip_y)
    );

    // heading and carried value ride alongside
    logic [A-1:0]  r_hd    [0:SIDE_D-1];
    logic [CW-1:0] r_carry [0:SIDE_D-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hd[0]    <= r_s1_hd;
            r_carry[0] <= r_s1_carry;
            for (int k = 1; k < SIDE_D; k++) begin
                r_hd[k]    <= r_hd[k-1];
                r_carry[k] <= r_carry[k-1];
            end
        end
    end

    // output register with skid buffer
    logic [PAY_W-1:0] w_pay;
    logic             w_push;
    logic             w_take;
    logic             r_out_valid;
    logic [PAY_W-1:0] r_out_pay;
    logic             r_skid_valid;
    logic [PAY_W-1:0] r_skid_pay;

    assign w_pay  = {w_clip_x | w_clip_y, r_carry[SIDE_D-1], r_hd[SIDE_D-1], w_ly, w_lx};
    assign w_en   = !r_skid_valid;
    assign w_push = w_en && w_sx_valid && w_sy_valid;
    assign w_take = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_pay    <= r_skid_pay;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_take) begin
                r_out_pay   <= w_pay;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_pay   <= w_pay;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_pay[OUT_RAW-1:0]);
    assign o_m_axis_tuser  = r_out_pay[PAY_W-1];

endmodule
